// ===== rtl/core/tanl_pkg.sv =====
// ----------------------------------------------------------------------------
// Typed address lookup package
// Shared constants, codes and types of the typed address nearest lookup core.
// ----------------------------------------------------------------------------
package tanl_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ADDR_W = 32;
    localparam int TYPE_W = 3;
    localparam int DIM_W  = 16;
    localparam int HALF_W = 16;
    localparam int STAT_W = 2;

    localparam logic [ADDR_W-1:0] UPPER_SEED = 32'h03FF_FFFF;
    localparam logic [ADDR_W-1:0] LOWER_SEED = 32'h0000_0001;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_HIT      = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISS     = 2'd3;

    typedef enum logic [1:0] {
        K_INSERTED,
        K_FULL,
        K_QUERY
    } t_res_kind;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [TYPE_W-1:0] etype;
        logic [DIM_W-1:0]  dim;
        logic              view;
    } t_entry;

    typedef struct packed {
        logic      write_entry;
        logic      scan_start;
        logic      scan_step;
        logic      load_result;
        t_res_kind kind;
    } t_dp_cmd;

    typedef struct packed {
        logic table_full;
        logic scan_done;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/core/tanl_if.sv =====
// ----------------------------------------------------------------------------
// Typed address lookup channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tanl_req_if import tanl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [ADDR_W-1:0] key_address;
    logic [TYPE_W-1:0] entry_type;
    logic [DIM_W-1:0]  entry_dim;
    logic              entry_view;

    modport source (output valid, mode, key_address, entry_type, entry_dim, entry_view,
                    input ready);
    modport sink (input valid, mode, key_address, entry_type, entry_dim, entry_view,
                  output ready);
endinterface

interface tanl_rsp_if import tanl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [TYPE_W-1:0] found_type;
    logic [HALF_W-1:0] dim_or_lower;
    logic [HALF_W-1:0] view_or_upper;

    modport source (output valid, status, found_type, dim_or_lower, view_or_upper,
                    input ready);
    modport sink (input valid, status, found_type, dim_or_lower, view_or_upper,
                  output ready);
endinterface

// ===== rtl/core/tanl_ctrl.sv =====
// ----------------------------------------------------------------------------
// Typed address lookup controller
// Sequences inserts, table scans and result hand-off for the datapath.
// ----------------------------------------------------------------------------
module tanl_ctrl import tanl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_mode,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state    r_state, n_state;
    t_res_kind r_kind, n_kind;
    logic      w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state           = r_state;
        n_kind            = r_kind;
        o_cmd.write_entry = 1'b0;
        o_cmd.scan_start  = 1'b0;
        o_cmd.scan_step   = 1'b0;
        o_cmd.load_result = 1'b0;
        o_cmd.kind        = r_kind;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_mode == MODE_INSERT) begin
                        o_cmd.write_entry = !i_sts.table_full;
                        n_kind  = i_sts.table_full ? K_FULL : K_INSERTED;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_kind  = K_QUERY;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_result = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= K_INSERTED;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

endmodule

// ===== rtl/core/tanl_datapath.sv =====
// ----------------------------------------------------------------------------
// Typed address lookup datapath
// Entry memory, fill count, scan pipeline with one comparator pair, and the
// response register.
// ----------------------------------------------------------------------------
module tanl_datapath import tanl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic [ADDR_W-1:0] i_key_address,
    input  logic [TYPE_W-1:0] i_entry_type,
    input  logic [DIM_W-1:0]  i_entry_dim,
    input  logic              i_entry_view,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [TYPE_W-1:0] o_found_type,
    output logic [HALF_W-1:0] o_dim_or_lower,
    output logic [HALF_W-1:0] o_view_or_upper
);

    t_entry            r_mem [TABLE_DEPTH];
    t_entry            r_rd_data;
    t_entry            r_hit_entry;
    logic              r_rd_vld;
    logic              r_hit;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_idx;
    logic [ADDR_W-1:0] r_key;
    logic [ADDR_W-1:0] r_upper;
    logic [ADDR_W-1:0] r_lower;
    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [TYPE_W-1:0] r_found_type;
    logic [HALF_W-1:0] r_dim_or_lower;
    logic [HALF_W-1:0] r_view_or_upper;

    logic              w_more;
    logic              w_eq;
    logic              w_above;
    logic              w_seg_ok;
    logic [STAT_W-1:0] n_status;
    logic [TYPE_W-1:0] n_found_type;
    logic [HALF_W-1:0] n_dim_or_lower;
    logic [HALF_W-1:0] n_view_or_upper;

    assign w_more  = (r_idx < r_count);
    assign w_eq    = (r_rd_data.addr == r_key);
    assign w_above = (r_rd_data.addr > r_key);

    assign o_sts.table_full = (r_count == CNT_W'(TABLE_DEPTH));
    assign o_sts.scan_done  = r_hit || (!r_rd_vld && !w_more);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_entry) begin
            r_mem[r_count[IDX_W-1:0]] <= '{addr: i_key_address, etype: i_entry_type,
                                           dim: i_entry_dim, view: i_entry_view};
        end
        if (i_cmd.scan_step) begin
            r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
        end else begin
            if (i_cmd.write_entry) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.scan_start) begin
                r_idx    <= '0;
                r_rd_vld <= 1'b0;
                r_hit    <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_rd_vld <= w_more;
                if (w_more) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
                if (r_rd_vld && w_eq) begin
                    r_hit <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_key   <= i_key_address;
            r_upper <= UPPER_SEED;
            r_lower <= LOWER_SEED;
        end else if (i_cmd.scan_step && r_rd_vld) begin
            if (w_eq) begin
                r_hit_entry <= r_rd_data;
            end else if (w_above) begin
                if (r_rd_data.addr < r_upper) begin
                    r_upper <= r_rd_data.addr;
                end
            end else begin
                if (r_rd_data.addr > r_lower) begin
                    r_lower <= r_rd_data.addr;
                end
            end
        end
    end

    assign w_seg_ok = (r_upper[ADDR_W-1:HALF_W] == r_key[ADDR_W-1:HALF_W])
                   && (r_lower[ADDR_W-1:HALF_W] == r_key[ADDR_W-1:HALF_W]);

    always_comb begin
        n_status        = ST_INSERTED;
        n_found_type    = '0;
        n_dim_or_lower  = '0;
        n_view_or_upper = '0;
        case (i_cmd.kind)
            K_INSERTED: begin
                n_status = ST_INSERTED;
            end
            K_FULL: begin
                n_status = ST_FULL;
            end
            K_QUERY: begin
                if (r_hit) begin
                    n_status        = ST_HIT;
                    n_found_type    = r_hit_entry.etype;
                    n_dim_or_lower  = r_hit_entry.dim;
                    n_view_or_upper = {{(HALF_W-1){1'b0}}, r_hit_entry.view};
                end else begin
                    n_status = ST_MISS;
                    if (w_seg_ok) begin
                        n_dim_or_lower  = r_lower[HALF_W-1:0];
                        n_view_or_upper = r_upper[HALF_W-1:0];
                    end
                end
            end
            default: begin
                n_status = ST_INSERTED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_status        <= n_status;
            r_found_type    <= n_found_type;
            r_dim_or_lower  <= n_dim_or_lower;
            r_view_or_upper <= n_view_or_upper;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_found_type    = r_found_type;
    assign o_dim_or_lower  = r_dim_or_lower;
    assign o_view_or_upper = r_view_or_upper;

endmodule

// ===== rtl/core/typed_address_nearest_lookup_core.sv =====
// ----------------------------------------------------------------------------
// Typed address nearest lookup core
// Table of typed addresses with exact lookup and nearest neighbor report.
//
//   Channel  Dir  Payload
//   i_req    in   mode, key_address, entry_type, entry_dim, entry_view
//   o_rsp    out  status, found_type, dim_or_lower, view_or_upper
//
// An insert loads the response register in the done state, once the output
// register is free. A query first runs the scan, which reads one table entry
// per cycle through one memory read port and a single comparator pair, and
// then loads it in the same way. An exact hit ends the scan early. Reset
// clears the entry count and all control state; table contents stay
// undefined until written. A response waiting in the output register does
// not block the next request transfer; only the load of the following
// response waits for it.
// ----------------------------------------------------------------------------
module typed_address_nearest_lookup_core import tanl_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tanl_req_if.sink   i_req,
    tanl_rsp_if.source o_rsp
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    assign i_req.ready = w_in_ready;

    tanl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_mode     (i_req.mode),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    tanl_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_key_address   (i_req.key_address),
        .i_entry_type    (i_req.entry_type),
        .i_entry_dim     (i_req.entry_dim),
        .i_entry_view    (i_req.entry_view),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_status        (o_rsp.status),
        .o_found_type    (o_rsp.found_type),
        .o_dim_or_lower  (o_rsp.dim_or_lower),
        .o_view_or_upper (o_rsp.view_or_upper)
    );

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && w_in_ready) |=> !w_in_ready)
        else $error("request accepted while previous one still in work");

    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.write_entry |-> !w_sts.table_full)
        else $error("entry written into a full table");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_result |-> w_sts.out_free)
        else $error("pending response overwritten");

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(w_cmd.load_result))
        else $error("response valid without a load");

endmodule

// ===== test/tb_typed_address_nearest_lookup_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Typed address nearest lookup core testbench
// Sends insert and query requests under varying source and sink idling. Each
// response is checked field by field against a local table mirror that
// predicts status, exact-hit contents and the nearest lower and upper
// neighbors.
// ----------------------------------------------------------------------------
module tb_typed_address_nearest_lookup_core;
    import tanl_pkg::*;

    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          DRAIN_CYCLES = 80;
    localparam int          MAX_PRINTS   = 100;
    localparam logic [15:0] BUSY_SEGMENT = 16'h0123;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [TYPE_W-1:0] found_type;
        logic [HALF_W-1:0] dim_or_lower;
        logic [HALF_W-1:0] view_or_upper;
    } t_lookup_rsp;

    logic i_clk;
    logic i_rst_n;

    tanl_req_if req_if ();
    tanl_rsp_if rsp_if ();

    typed_address_nearest_lookup_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_entry      mirror_entries [TABLE_DEPTH];
    int          mirror_count;
    t_lookup_rsp pending_results [$];
    t_lookup_rsp got_rsp;
    t_lookup_rsp want_rsp;
    int          error_count;
    int          cycle_count;
    int          send_idle_pct;
    int          stall_pct;

    always #5 i_clk = ~i_clk;

    function automatic t_lookup_rsp lookup_result(input logic m, input logic [ADDR_W-1:0] key,
                                                  input logic [TYPE_W-1:0] et,
                                                  input logic [DIM_W-1:0] ed, input logic ev);
        t_lookup_rsp       r;
        logic [ADDR_W-1:0] up;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] a;
        r  = '0;
        up = UPPER_SEED;
        lo = LOWER_SEED;
        if (m == MODE_INSERT) begin
            if (mirror_count >= TABLE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                mirror_entries[mirror_count].addr  = key;
                mirror_entries[mirror_count].etype = et;
                mirror_entries[mirror_count].dim   = ed;
                mirror_entries[mirror_count].view  = ev;
                mirror_count++;
                r.status = ST_INSERTED;
            end
            return r;
        end
        for (int i = 0; i < mirror_count; i++) begin
            a = mirror_entries[i].addr;
            if (a == key) begin
                r.status        = ST_HIT;
                r.found_type    = mirror_entries[i].etype;
                r.dim_or_lower  = mirror_entries[i].dim;
                r.view_or_upper = {{(HALF_W-1){1'b0}}, mirror_entries[i].view};
                return r;
            end else if (a > key) begin
                if (a < up) begin
                    up = a;
                end
            end else if (a > lo) begin
                lo = a;
            end
        end
        r.status = ST_MISS;
        if (up[31:16] == key[31:16] && lo[31:16] == key[31:16]) begin
            r.dim_or_lower  = lo[15:0];
            r.view_or_upper = up[15:0];
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] random_address();
        logic [15:0] seg;
        logic [15:0] off;
        case ($urandom_range(5))
            0: seg = 16'h0000;
            1: seg = 16'h03FF;
            2, 3: seg = BUSY_SEGMENT;
            4: seg = 16'($urandom_range(16'h03FF));
            default: return $urandom;
        endcase
        case ($urandom_range(7))
            0: off = 16'h0000;
            1: off = 16'hFFFF;
            2: off = 16'h0001;
            default: off = 16'($urandom_range(65535));
        endcase
        return {seg, off};
    endfunction

    function automatic logic [ADDR_W-1:0] random_query_key();
        logic [ADDR_W-1:0] base;
        int                pick;
        pick = $urandom_range(9);
        if (mirror_count == 0 || pick >= 7) begin
            return (pick == 9) ? $urandom : random_address();
        end
        base = mirror_entries[$urandom_range(mirror_count - 1)].addr;
        if (pick < 4) begin
            return base;
        end else if (pick < 6) begin
            return base + $urandom_range(1, 4);
        end
        return base - $urandom_range(1, 4);
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTS) begin
            $display("%0t: mismatch: %s", $realtime, msg);
        end
        error_count++;
    endtask

    task automatic send_item(input logic m, input logic [ADDR_W-1:0] key,
                             input logic [TYPE_W-1:0] et, input logic [DIM_W-1:0] ed,
                             input logic ev);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.mode        <= m;
        req_if.key_address <= key;
        req_if.entry_type  <= et;
        req_if.entry_dim   <= ed;
        req_if.entry_view  <= ev;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
        pending_results.push_back(lookup_result(m, key, et, ed, ev));
    endtask

    task automatic send_insert(input logic [ADDR_W-1:0] key, input logic [TYPE_W-1:0] et,
                               input logic [DIM_W-1:0] ed, input logic ev);
        send_item(MODE_INSERT, key, et, ed, ev);
    endtask

    task automatic send_query(input logic [ADDR_W-1:0] key);
        send_item(MODE_QUERY, key, TYPE_W'($urandom_range(7)),
                  DIM_W'($urandom_range(65535)), 1'($urandom_range(1)));
    endtask

    task automatic send_random_insert();
        send_insert(random_address(), TYPE_W'($urandom_range(7)),
                    DIM_W'($urandom_range(65535)), 1'($urandom_range(1)));
    endtask

    task automatic test_empty_table();
        send_query(32'h0000_0000);
        send_query(32'hFFFF_FFFF);
        send_query(32'h03FF_FFFF);
        send_query(32'h03FF_8000);
        send_query(32'h0000_0001);
    endtask

    task automatic test_directed_lookup();
        send_insert(32'h0000_0000, 3'd0, 16'h0000, 1'b0);
        send_insert(32'hFFFF_FFFF, 3'd7, 16'hFFFF, 1'b1);
        send_insert(32'h03FF_FFFF, 3'd5, 16'h0001, 1'b1);
        send_insert(32'h0000_0001, 3'd1, 16'h0002, 1'b0);
        send_insert(32'h0123_0040, 3'd2, 16'h0040, 1'b1);
        send_insert(32'h0123_0010, 3'd3, 16'h8000, 1'b0);
        send_insert(32'h0123_0080, 3'd4, 16'h7FFF, 1'b1);
        send_insert(32'h0123_0040, 3'd5, 16'h1234, 1'b0);
        send_insert(32'h03FF_1000, 3'd1, 16'h0003, 1'b1);
        send_insert(32'h0000_0100, 3'd6, 16'h0004, 1'b0);
        send_query(32'hFFFF_FFFF);
        send_query(32'h0123_0040);
        send_query(32'h0123_0050);
        send_query(32'h0123_0005);
        send_query(32'h03FF_2000);
        send_query(32'h0000_0005);
        send_query(32'h0000_0000);
        send_query(32'h0123_00A0);
        send_query(32'h03FF_FFFF);
    endtask

    task automatic test_full_table();
        while (mirror_count < TABLE_DEPTH) begin
            send_random_insert();
        end
        send_insert(32'h0000_0000, 3'd0, 16'h0000, 1'b0);
        send_insert(32'hFFFF_FFFF, 3'd7, 16'hFFFF, 1'b1);
        send_insert(32'h0123_0055, 3'd3, 16'hA5A5, 1'b1);
        send_query(mirror_entries[TABLE_DEPTH-1].addr);
        send_query(32'h0123_0055);
    endtask

    task automatic test_random_traffic(input int n_items, input int idle, input int stall);
        send_idle_pct = idle;
        stall_pct     = stall;
        repeat (n_items) begin
            if ($urandom_range(99) < ((mirror_count < TABLE_DEPTH) ? 20 : 10)) begin
                send_random_insert();
            end else begin
                send_query(random_query_key());
            end
        end
    endtask

    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got_rsp.status        = rsp_if.status;
            got_rsp.found_type    = rsp_if.found_type;
            got_rsp.dim_or_lower  = rsp_if.dim_or_lower;
            got_rsp.view_or_upper = rsp_if.view_or_upper;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("response with nothing pending: %h", got_rsp));
            end else begin
                want_rsp = pending_results.pop_front();
                if (got_rsp.status !== want_rsp.status) begin
                    report_mismatch($sformatf("status expected %0d got %0d",
                                              want_rsp.status, got_rsp.status));
                end
                if (got_rsp.found_type !== want_rsp.found_type) begin
                    report_mismatch($sformatf("found_type expected %0d got %0d",
                                              want_rsp.found_type, got_rsp.found_type));
                end
                if (got_rsp.dim_or_lower !== want_rsp.dim_or_lower) begin
                    report_mismatch($sformatf("dim_or_lower expected %h got %h",
                                              want_rsp.dim_or_lower, got_rsp.dim_or_lower));
                end
                if (got_rsp.view_or_upper !== want_rsp.view_or_upper) begin
                    report_mismatch($sformatf("view_or_upper expected %h got %h",
                                              want_rsp.view_or_upper, got_rsp.view_or_upper));
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.mode        = MODE_INSERT;
        req_if.key_address = '0;
        req_if.entry_type  = '0;
        req_if.entry_dim   = '0;
        req_if.entry_view  = 1'b0;
        rsp_if.ready       = 1'b0;
        mirror_count       = 0;
        error_count        = 0;
        send_idle_pct      = 0;
        stall_pct          = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_directed_lookup();
        test_random_traffic(380, 0, 0);
        test_full_table();
        test_random_traffic(380, 49, 0);
        test_random_traffic(380, 0, 49);
        test_random_traffic(380, 15, 15);

        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
